// File: design/wwvb_pulse_deframer_macros.svh
// ----------------------------------------------------------------------------
// WWVB pulse deframer assertion macros
// Implication and next-cycle checks, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef WWVB_PULSE_DEFRAMER_MACROS_SVH
`define WWVB_PULSE_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define WPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define WPD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define WPD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define WPD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: design/wpd_pkg.sv
// ----------------------------------------------------------------------------
// WWVB pulse deframer package
// Symbol codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package wpd_pkg;

   localparam int HISTORY_LEN_DEF = 10;

   localparam int WIDTH_W  = 16;
   localparam int SYM_W    = 3;
   localparam int CNT_W    = 7;
   localparam int FRAME_W  = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [SYM_W-1:0] SYM_MARKER    = 3'd0;
   localparam logic [SYM_W-1:0] SYM_ONE       = 3'd1;
   localparam logic [SYM_W-1:0] SYM_ZERO      = 3'd2;
   localparam logic [SYM_W-1:0] SYM_UNMATCHED = 3'd3;
   localparam logic [SYM_W-1:0] SYM_INVALID   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER_MAX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MIN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MAX     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_MIN    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_MAX    = 3'd7;

   localparam logic [WIDTH_W-1:0] RST_FULL_SCALE = 16'd32768;
   localparam logic [WIDTH_W-1:0] RST_MARKER_MIN = 16'd24050;
   localparam logic [WIDTH_W-1:0] RST_MARKER_MAX = 16'd27992;
   localparam logic [WIDTH_W-1:0] RST_ONE_MIN    = 16'd14675;
   localparam logic [WIDTH_W-1:0] RST_ONE_MAX    = 16'd19350;
   localparam logic [WIDTH_W-1:0] RST_ZERO_MIN   = 16'd5775;
   localparam logic [WIDTH_W-1:0] RST_ZERO_MAX   = 16'd10025;

   localparam logic [CNT_W-1:0] CNT_MAX       = 7'd127;
   localparam logic [CNT_W-1:0] FRAME_MARKERS = 7'd7;
   localparam logic [CNT_W-1:0] FRAME_BITS    = 7'd60;
   localparam logic [1:0]       RUN_RESTART   = 2'd2;
   localparam logic [1:0]       RUN_MAX       = 2'd3;

   localparam int QUAL_SCALE = 100;
   localparam int QUAL_W     = 7;
   localparam int QUOT_W     = 8;
   localparam int PAIR_W     = $clog2(QUOT_W / 2);

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef logic [SYM_W-1:0] wpd_symbol_type;

   typedef struct packed {
      logic                sync_enable;
      logic [WIDTH_W-1:0] full_scale;
      logic [WIDTH_W-1:0] marker_min;
      logic [WIDTH_W-1:0] marker_max;
      logic [WIDTH_W-1:0] one_min;
      logic [WIDTH_W-1:0] one_max;
      logic [WIDTH_W-1:0] zero_min;
      logic [WIDTH_W-1:0] zero_max;
   } wpd_cfg_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } wpd_qstat_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

endpackage

// File: design/wpd_front.sv
// ----------------------------------------------------------------------------
// WWVB pulse deframer front end
// Holds the window registers and classifies each request into a symbol.
// ----------------------------------------------------------------------------
module wpd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [wpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wpd_pkg::WIDTH_W-1:0]      csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [wpd_pkg::WIDTH_W-1:0]      req_pulse_width,
   input  wpd_pkg::wpd_qstat_type            q_stat,
   output logic                              q_push,
   output wpd_pkg::wpd_symbol_type           q_push_data
);
   import wpd_pkg::*;

   wpd_cfg_type cfg_ff;
   wpd_cfg_type cfg_in;
   logic        width_ok;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SYNC_ENABLE: cfg_in.sync_enable = csr_wdata[0];
            CSR_FULL_SCALE:  cfg_in.full_scale  = csr_wdata;
            CSR_MARKER_MIN:  cfg_in.marker_min  = csr_wdata;
            CSR_MARKER_MAX:  cfg_in.marker_max  = csr_wdata;
            CSR_ONE_MIN:     cfg_in.one_min     = csr_wdata;
            CSR_ONE_MAX:     cfg_in.one_max     = csr_wdata;
            CSR_ZERO_MIN:    cfg_in.zero_min    = csr_wdata;
            CSR_ZERO_MAX:    cfg_in.zero_max    = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_enable <= 1'b1;
         cfg_ff.full_scale  <= RST_FULL_SCALE;
         cfg_ff.marker_min  <= RST_MARKER_MIN;
         cfg_ff.marker_max  <= RST_MARKER_MAX;
         cfg_ff.one_min     <= RST_ONE_MIN;
         cfg_ff.one_max     <= RST_ONE_MAX;
         cfg_ff.zero_min    <= RST_ZERO_MIN;
         cfg_ff.zero_max    <= RST_ZERO_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // With sync disabled a request is taken and dropped.
   assign req_stall = cfg_ff.sync_enable & q_stat.full;
   assign q_push    = req_valid & ~req_stall & cfg_ff.sync_enable;

   assign width_ok = ~req_func && (req_pulse_width != '0) &&
                     (req_pulse_width < cfg_ff.full_scale);

   always_comb begin
      if (!width_ok) begin
         q_push_data = SYM_INVALID;
      end else if (req_pulse_width >= cfg_ff.marker_min &&
                   req_pulse_width <= cfg_ff.marker_max) begin
         q_push_data = SYM_MARKER;
      end else if (req_pulse_width >= cfg_ff.one_min &&
                   req_pulse_width <= cfg_ff.one_max) begin
         q_push_data = SYM_ONE;
      end else if (req_pulse_width >= cfg_ff.zero_min &&
                   req_pulse_width <= cfg_ff.zero_max) begin
         q_push_data = SYM_ZERO;
      end else begin
         q_push_data = SYM_UNMATCHED;
      end
   end

endmodule

// File: design/wpd_queue.sv
// ----------------------------------------------------------------------------
// WWVB pulse deframer symbol queue
// A short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module wpd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wpd_pkg::wpd_symbol_type   push_data,
   input  logic                      pop,
   output wpd_pkg::wpd_symbol_type   pop_data,
   output wpd_pkg::wpd_qstat_type    stat
);
   import wpd_pkg::*;

   wpd_symbol_type       mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff;
   logic [Q_CNT_W-1:0]   count_in;

   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign pop_data       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/wpd_back.sv
// ----------------------------------------------------------------------------
// WWVB pulse deframer back end
// Updates the frame state per symbol and works out the signal quality.
// ----------------------------------------------------------------------------
module wpd_back #(
   parameter int HISTORY_LEN = wpd_pkg::HISTORY_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wpd_pkg::wpd_qstat_type           q_stat,
   input  wpd_pkg::wpd_symbol_type          q_pop_data,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [wpd_pkg::SYM_W-1:0]       rsp_symbol,
   output logic                             rsp_good_read,
   output logic                             rsp_frame_done,
   output logic [wpd_pkg::FRAME_W-1:0]     rsp_frame_bits,
   output logic [wpd_pkg::CNT_W-1:0]       rsp_bit_count,
   output logic [wpd_pkg::CNT_W-1:0]       rsp_marker_total,
   output logic [wpd_pkg::QUAL_W-1:0]      rsp_signal_quality
);
   import wpd_pkg::*;

   localparam int GW = $clog2(HISTORY_LEN + 1);
   localparam int PW = GW + QUAL_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic [CNT_W-1:0]       mc_ff, mc_in;
   logic [CNT_W-1:0]       bc_ff, bc_in;
   logic [1:0]             run_ff, run_in;
   logic [HISTORY_LEN-1:0] hist_ff, hist_in;
   logic [GW-1:0]          goods_ff, goods_in;
   logic [GW-1:0]          fill_ff, fill_in;
   wpd_symbol_type         sym_ff, sym_in;
   logic                   good_ff, good_in;
   logic                   done_ff, done_in;
   logic [PW-1:0]          rem_ff, rem_in;
   logic [QUOT_W-1:0]      quot_ff, quot_in;
   logic [PAIR_W-1:0]      pair_ff, pair_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;
   logic                   load_out;
   logic [PW-1:0]          div_rem;
   logic [QUOT_W-1:0]      div_quot;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) & q_stat.not_empty;
   assign load_out = (state_ff == ST_OUT) & out_free;

   // Frame and history update for the symbol at the head of the queue.
   always_comb begin
      frame_in = frame_ff;
      mc_in    = mc_ff;
      bc_in    = bc_ff;
      run_in   = run_ff;
      good_in  = 1'b0;
      done_in  = 1'b0;
      case (q_pop_data)
         SYM_MARKER: begin
            frame_in = frame_ff << 1;
            good_in  = 1'b1;
            mc_in    = sat_inc(mc_ff);
            bc_in    = sat_inc(bc_ff);
            run_in   = (run_ff != RUN_MAX) ? run_ff + 1'b1 : run_ff;
            if (run_in == RUN_RESTART) begin
               mc_in = CNT_W'(1);
               bc_in = CNT_W'(1);
            end else if (mc_in == FRAME_MARKERS && bc_in == FRAME_BITS) begin
               done_in = 1'b1;
               mc_in   = '0;
               bc_in   = '0;
            end
         end
         SYM_ONE: begin
            frame_in = {frame_ff[FRAME_W-2:0], 1'b1};
            good_in  = 1'b1;
            run_in   = '0;
            bc_in    = sat_inc(bc_ff);
         end
         SYM_ZERO: begin
            frame_in = frame_ff << 1;
            good_in  = 1'b1;
            run_in   = '0;
            bc_in    = sat_inc(bc_ff);
         end
         SYM_UNMATCHED: begin
            frame_in = frame_ff << 1;
         end
         default: begin
            frame_in = frame_ff;
         end
      endcase
      if (!good_in) begin
         mc_in = '0;
         bc_in = '0;
      end
      fill_in  = (fill_ff != GW'(HISTORY_LEN)) ? fill_ff + 1'b1 : fill_ff;
      hist_in  = (hist_ff << 1) | HISTORY_LEN'(good_in);
      goods_in = goods_ff + GW'(good_in) - GW'(hist_ff[HISTORY_LEN-1]);
      sym_in   = q_pop_data;
   end

   // Two restoring quotient bits per cycle, highest pair first.
   always_comb begin
      logic [PW-1:0] trial;
      logic [2:0]    sh;
      div_rem  = rem_ff;
      div_quot = quot_ff;
      for (int j = 0; j < 2; j++) begin
         sh    = {pair_ff, (j == 0)};
         trial = PW'(fill_ff) << sh;
         if (div_rem >= trial) begin
            div_rem      = div_rem - trial;
            div_quot[sh] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      pair_in  = pair_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_stat.not_empty) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            rem_in   = PW'(goods_ff) * PW'(QUAL_SCALE);
            quot_in  = '0;
            pair_in  = '1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_rem;
            quot_in = div_quot;
            pair_in = pair_ff - 1'b1;
            if (pair_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= '0;
         mc_ff        <= '0;
         bc_ff        <= '0;
         run_ff       <= '0;
         hist_ff      <= '0;
         goods_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            frame_ff <= frame_in;
            mc_ff    <= mc_in;
            bc_ff    <= bc_in;
            run_ff   <= run_in;
            hist_ff  <= hist_in;
            goods_ff <= goods_in;
            fill_ff  <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      pair_ff <= pair_in;
      if (q_pop) begin
         sym_ff  <= sym_in;
         good_ff <= good_in;
         done_ff <= done_in;
      end
      if (load_out) begin
         rsp_symbol         <= sym_ff;
         rsp_good_read      <= good_ff;
         rsp_frame_done     <= done_ff;
         rsp_frame_bits     <= frame_ff;
         rsp_bit_count      <= bc_ff;
         rsp_marker_total   <= mc_ff;
         rsp_signal_quality <= quot_ff[QUAL_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/wwvb_pulse_deframer.sv
// ----------------------------------------------------------------------------
// WWVB pulse deframer
// Classifies captured pulse widths, builds the frame and tracks signal quality.
// ----------------------------------------------------------------------------
//   Channel   Handshake            Payload
//   req_      req_valid/req_stall  func, pulse_width
//   rsp_      rsp_valid/rsp_stall  symbol, good_read, frame_done, frame_bits,
//                                  bit_count, marker_total, signal_quality
//   csr_      csr_write_enable     csr_index, csr_wdata
//
// A taken request passes through the queue to the back end, which updates the
// frame state, scales the good-read count, runs the two-bit-per-cycle quality
// divider and loads the result register, waiting while that register is held.
// The back end takes the next request only after it has loaded the last one.
// A two-entry queue lets the front end take requests while the back end or
// the result register is busy. Reset is synchronous and needs no clearing
// pass. With sync disabled requests are taken and give no result.
`include "wwvb_pulse_deframer_macros.svh"

module wwvb_pulse_deframer #(
   parameter int HISTORY_LEN = wpd_pkg::HISTORY_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [wpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wpd_pkg::WIDTH_W-1:0]      csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [wpd_pkg::WIDTH_W-1:0]      req_pulse_width,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wpd_pkg::SYM_W-1:0]       rsp_symbol,
   output logic                              rsp_good_read,
   output logic                              rsp_frame_done,
   output logic [wpd_pkg::FRAME_W-1:0]     rsp_frame_bits,
   output logic [wpd_pkg::CNT_W-1:0]       rsp_bit_count,
   output logic [wpd_pkg::CNT_W-1:0]       rsp_marker_total,
   output logic [wpd_pkg::QUAL_W-1:0]      rsp_signal_quality
);
   import wpd_pkg::*;

   wpd_qstat_type  q_stat;
   logic           q_push;
   logic           q_pop;
   wpd_symbol_type q_push_data;
   wpd_symbol_type q_pop_data;

   wpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_pulse_width  (req_pulse_width),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   wpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   wpd_back #(
      .HISTORY_LEN (HISTORY_LEN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_stat             (q_stat),
      .q_pop_data         (q_pop_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol         (rsp_symbol),
      .rsp_good_read      (rsp_good_read),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_bits     (rsp_frame_bits),
      .rsp_bit_count      (rsp_bit_count),
      .rsp_marker_total   (rsp_marker_total),
      .rsp_signal_quality (rsp_signal_quality)
   );

   `WPD_ASSERT_IMP(a_done_clears, clock, reset, rsp_valid && rsp_frame_done,
      rsp_symbol == SYM_MARKER && rsp_bit_count == '0 && rsp_marker_total == '0,
      "Completed frame did not clear the counters.")
   `WPD_ASSERT_IMP(a_good_symbol, clock, reset, rsp_valid,
      rsp_good_read == (rsp_symbol == SYM_MARKER || rsp_symbol == SYM_ONE ||
                        rsp_symbol == SYM_ZERO),
      "Good read flag disagrees with the symbol.")
   `WPD_ASSERT_IMP(a_quality_range, clock, reset, rsp_valid,
      rsp_signal_quality <= QUAL_W'(QUAL_SCALE), "Signal quality above one hundred.")
   `WPD_ASSERT_IMP(a_no_overflow, clock, reset, q_push, !q_stat.full || q_pop,
      "Request pushed into a full queue.")
   `WPD_ASSERT_NXT(a_push_lands, clock, reset, q_push && !q_pop, q_stat.not_empty,
      "Pushed request missing from the queue.")

endmodule

// File: sim/wwvb_pulse_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WWVB pulse deframer testbench
// Feeds pulse events through the request channel and checks every report. A
// scoreboard predicts the symbol, the frame register, the counters and the
// signal quality of each request taken with sync enabled. The stimulus is a
// short directed set, whole minutes of well-formed frames with random content
// and noise under reset and random windows, and extreme settings. Both sides
// idle at random, and the receiver also holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module wwvb_pulse_deframer_tb;
   import wpd_pkg::*;

   typedef struct packed {
      wpd_symbol_type      symbol;
      logic                good_read;
      logic                frame_done;
      logic [FRAME_W-1:0]  frame_bits;
      logic [CNT_W-1:0]    bit_count;
      logic [CNT_W-1:0]    marker_total;
      logic [QUAL_W-1:0]   signal_quality;
   } deframe_report_type;

   localparam wpd_cfg_type RESET_SETTING = '{
      sync_enable: 1'b1,
      full_scale:  RST_FULL_SCALE,
      marker_min:  RST_MARKER_MIN,
      marker_max:  RST_MARKER_MAX,
      one_min:     RST_ONE_MIN,
      one_max:     RST_ONE_MAX,
      zero_min:    RST_ZERO_MIN,
      zero_max:    RST_ZERO_MAX
   };

   class deframe_scoreboard;
      wpd_cfg_type                  cfg;
      logic [FRAME_W-1:0]           frame_reg;
      logic [CNT_W-1:0]             marker_cnt;
      logic [CNT_W-1:0]             bit_cnt;
      logic [1:0]                   run_len;
      logic [HISTORY_LEN_DEF-1:0]   good_hist;
      int                           hist_fill;
      deframe_report_type           pending_reports[$];
      int                           mismatches;

      function new();
         cfg        = RESET_SETTING;
         frame_reg  = '0;
         marker_cnt = '0;
         bit_cnt    = '0;
         run_len    = '0;
         good_hist  = '0;
         hist_fill  = 0;
         mismatches = 0;
      endfunction

      function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
         return (v == CNT_MAX) ? v : v + 1'b1;
      endfunction

      function string describe(input deframe_report_type r);
         return $sformatf("sym %0d good %0d done %0d bits %h bc %0d mc %0d q %0d",
                          r.symbol, r.good_read, r.frame_done, r.frame_bits,
                          r.bit_count, r.marker_total, r.signal_quality);
      endfunction

      function void classify_pulse(input logic func, input logic [WIDTH_W-1:0] w);
         deframe_report_type r;
         int                 goods;
         if (!cfg.sync_enable) return;
         r.symbol     = SYM_INVALID;
         r.good_read  = 1'b0;
         r.frame_done = 1'b0;
         if (!func && w != '0 && w < cfg.full_scale) begin
            frame_reg = frame_reg << 1;
            if (w >= cfg.marker_min && w <= cfg.marker_max) begin
               r.symbol    = SYM_MARKER;
               r.good_read = 1'b1;
               marker_cnt  = bump(marker_cnt);
               bit_cnt     = bump(bit_cnt);
               if (run_len != RUN_MAX) run_len++;
               if (run_len == RUN_RESTART) begin
                  marker_cnt = 7'd1;
                  bit_cnt    = 7'd1;
               end else if (marker_cnt == FRAME_MARKERS && bit_cnt == FRAME_BITS) begin
                  r.frame_done = 1'b1;
                  marker_cnt   = '0;
                  bit_cnt      = '0;
               end
            end else if (w >= cfg.one_min && w <= cfg.one_max) begin
               r.symbol     = SYM_ONE;
               r.good_read  = 1'b1;
               run_len      = '0;
               bit_cnt      = bump(bit_cnt);
               frame_reg[0] = 1'b1;
            end else if (w >= cfg.zero_min && w <= cfg.zero_max) begin
               r.symbol    = SYM_ZERO;
               r.good_read = 1'b1;
               run_len     = '0;
               bit_cnt     = bump(bit_cnt);
            end else begin
               r.symbol = SYM_UNMATCHED;
            end
         end
         if (hist_fill < HISTORY_LEN_DEF) hist_fill++;
         good_hist = {good_hist[HISTORY_LEN_DEF-2:0], r.good_read};
         if (!r.good_read) begin
            marker_cnt = '0;
            bit_cnt    = '0;
         end
         goods            = $countones(good_hist);
         r.frame_bits     = frame_reg;
         r.bit_count      = bit_cnt;
         r.marker_total   = marker_cnt;
         r.signal_quality = QUAL_W'((goods * QUAL_SCALE) / hist_fill);
         pending_reports.push_back(r);
      endfunction

      function void check_report(input deframe_report_type got);
         deframe_report_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected report: %s", describe(got));
            return;
         end
         want = pending_reports.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Report mismatch, expected: %s", describe(want));
               $display("                 actual:   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [WIDTH_W-1:0]     csr_wdata        = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_func         = 1'b0;
   logic [WIDTH_W-1:0]     req_pulse_width  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [SYM_W-1:0]       rsp_symbol;
   logic                   rsp_good_read;
   logic                   rsp_frame_done;
   logic [FRAME_W-1:0]     rsp_frame_bits;
   logic [CNT_W-1:0]       rsp_bit_count;
   logic [CNT_W-1:0]       rsp_marker_total;
   logic [QUAL_W-1:0]      rsp_signal_quality;

   deframe_scoreboard      sb;
   bit                     req_gaps  = 1'b0;
   bit                     rsp_gaps  = 1'b0;
   bit                     long_hold = 1'b0;
   int                     minute_pos = 59;

   wwvb_pulse_deframer u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_pulse_width    (req_pulse_width),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol         (rsp_symbol),
      .rsp_good_read      (rsp_good_read),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_bits     (rsp_frame_bits),
      .rsp_bit_count      (rsp_bit_count),
      .rsp_marker_total   (rsp_marker_total),
      .rsp_signal_quality (rsp_signal_quality)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin : watch
      deframe_report_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) sb.classify_pulse(req_func, req_pulse_width);
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_symbol, rsp_good_read, rsp_frame_done, rsp_frame_bits,
                     rsp_bit_count, rsp_marker_total, rsp_signal_quality};
            sb.check_report(seen);
         end
      end
   end

   // The long hold-off is counted here, while the sender keeps offering requests.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_gaps && $urandom_range(3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(4, 1)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_request(input logic func, input logic [WIDTH_W-1:0] width);
      req_valid       <= 1'b1;
      req_func        <= func;
      req_pulse_width <= width;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (req_gaps && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // Waits for every outstanding report, then lets requests that give none drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic apply_setting(input wpd_cfg_type s);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SYNC_ENABLE;
      csr_wdata <= {{(WIDTH_W-1){1'b0}}, s.sync_enable};
      @(posedge clock);
      csr_index <= CSR_FULL_SCALE;
      csr_wdata <= s.full_scale;
      @(posedge clock);
      csr_index <= CSR_MARKER_MIN;
      csr_wdata <= s.marker_min;
      @(posedge clock);
      csr_index <= CSR_MARKER_MAX;
      csr_wdata <= s.marker_max;
      @(posedge clock);
      csr_index <= CSR_ONE_MIN;
      csr_wdata <= s.one_min;
      @(posedge clock);
      csr_index <= CSR_ONE_MAX;
      csr_wdata <= s.one_max;
      @(posedge clock);
      csr_index <= CSR_ZERO_MIN;
      csr_wdata <= s.zero_min;
      @(posedge clock);
      csr_index <= CSR_ZERO_MAX;
      csr_wdata <= s.zero_max;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.cfg = s;
   endtask

   function automatic wpd_cfg_type random_setting();
      wpd_cfg_type s;
      int          lo;
      s.sync_enable = 1'b1;
      s.full_scale  = WIDTH_W'($urandom_range(65535, 1000));
      lo            = $urandom_range(60000);
      s.marker_min  = WIDTH_W'(lo);
      s.marker_max  = WIDTH_W'(lo + $urandom_range(5535));
      lo            = $urandom_range(60000);
      s.one_min     = WIDTH_W'(lo);
      s.one_max     = WIDTH_W'(lo + $urandom_range(5535));
      lo            = $urandom_range(60000);
      s.zero_min    = WIDTH_W'(lo);
      s.zero_max    = WIDTH_W'(lo + $urandom_range(5535));
      return s;
   endfunction

   function automatic logic [WIDTH_W-1:0] width_for(input wpd_symbol_type kind);
      wpd_cfg_type        c;
      logic [WIDTH_W-1:0] w;
      c = sb.cfg;
      w = WIDTH_W'($urandom);
      case (kind)
         SYM_MARKER: if (c.marker_min <= c.marker_max)
            w = WIDTH_W'($urandom_range(c.marker_max, c.marker_min));
         SYM_ONE: if (c.one_min <= c.one_max)
            w = WIDTH_W'($urandom_range(c.one_max, c.one_min));
         SYM_ZERO: if (c.zero_min <= c.zero_max)
            w = WIDTH_W'($urandom_range(c.zero_max, c.zero_min));
         SYM_UNMATCHED: if (c.full_scale > 1) begin
            for (int tries = 0; tries < 16; tries++) begin
               w = WIDTH_W'($urandom_range(c.full_scale - 1, 1));
               if (!(w >= c.marker_min && w <= c.marker_max) &&
                   !(w >= c.one_min && w <= c.one_max) &&
                   !(w >= c.zero_min && w <= c.zero_max)) break;
            end
         end
         default: w = ($urandom_range(1) == 0) ? '0 :
                      WIDTH_W'($urandom_range(16'hFFFF, c.full_scale));
      endcase
      return w;
   endfunction

   // Whole minutes: markers at second zero and the ninth second of every decade,
   // with timeouts, bad widths, stray markers and jumps mixed in as noise.
   task automatic run_frames(input int count, input int noise_pct);
      wpd_symbol_type kind;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(4))
               0: send_request(1'b1, WIDTH_W'($urandom));
               1: send_request(1'b0, width_for(SYM_INVALID));
               2: send_request(1'b0, width_for(SYM_UNMATCHED));
               3: send_request(1'b0, width_for(SYM_MARKER));
               default: minute_pos = $urandom_range(59);
            endcase
         end else begin
            if (minute_pos == 0 || minute_pos % 10 == 9) kind = SYM_MARKER;
            else kind = ($urandom_range(1) == 0) ? SYM_ONE : SYM_ZERO;
            send_request(1'b0, width_for(kind));
            minute_pos = (minute_pos + 1) % 60;
         end
      end
   endtask

   task automatic run_loose(input int count);
      logic [WIDTH_W-1:0] w;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            default: w = WIDTH_W'($urandom);
         endcase
         send_request($urandom_range(9) == 0, w);
      end
   endtask

   initial begin
      wpd_cfg_type setting;
      sb = new();
      repeat (8) @(posedge clock);
      reset    <= 1'b0;
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;

      send_request(1'b1, '0);
      send_request(1'b1, 16'd26000);
      send_request(1'b0, '0);
      send_request(1'b0, '1);
      send_request(1'b0, RST_FULL_SCALE);
      send_request(1'b0, RST_FULL_SCALE - 1'b1);
      send_request(1'b0, 16'd1);
      send_request(1'b0, RST_ZERO_MIN);
      send_request(1'b0, RST_ZERO_MAX);
      send_request(1'b0, RST_ZERO_MIN - 1'b1);
      send_request(1'b0, RST_ZERO_MAX + 1'b1);
      send_request(1'b0, RST_ONE_MIN);
      send_request(1'b0, RST_ONE_MAX);
      send_request(1'b0, RST_ONE_MAX + 1'b1);
      send_request(1'b0, RST_ONE_MIN - 1'b1);
      send_request(1'b0, RST_MARKER_MIN);
      send_request(1'b0, RST_MARKER_MAX);
      send_request(1'b0, RST_MARKER_MIN);
      send_request(1'b0, RST_MARKER_MAX + 1'b1);
      send_request(1'b0, RST_MARKER_MIN - 1'b1);
      send_request(1'b0, RST_ZERO_MIN);
      send_request(1'b0, RST_MARKER_MAX);
      send_request(1'b1, '1);
      settle();

      run_frames(150, 5);
      long_hold = 1'b1;
      run_frames(150, 10);
      settle();

      for (int k = 0; k < 3; k++) begin
         apply_setting(random_setting());
         run_frames(100, 15);
         settle();
      end

      // Every valid width is a marker, so the marker run reaches its maximum.
      setting            = RESET_SETTING;
      setting.full_scale = '1;
      setting.marker_min = '0;
      setting.marker_max = '1;
      setting.one_min    = '1;
      setting.one_max    = '0;
      setting.zero_min   = '0;
      setting.zero_max   = '1;
      apply_setting(setting);
      run_loose(100);
      settle();

      // Every valid width is a one, so the bit counter climbs until an invalid request clears it.
      setting.marker_min = '1;
      setting.marker_max = '0;
      setting.one_min    = '0;
      setting.one_max    = '1;
      setting.zero_min   = '1;
      setting.zero_max   = '1;
      apply_setting(setting);
      run_loose(160);
      settle();

      setting            = RESET_SETTING;
      setting.full_scale = 16'd1;
      setting.zero_max   = '0;
      apply_setting(setting);
      run_loose(40);
      settle();

      setting             = RESET_SETTING;
      setting.sync_enable = 1'b0;
      apply_setting(setting);
      run_loose(60);
      settle();

      apply_setting(RESET_SETTING);
      run_frames(100, 10);
      for (int n = 0; n < 256; n++)
         send_request(1'b0, width_for((n % 2 == 0) ? SYM_MARKER : SYM_ONE));
      run_frames(50, 5);

      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_frames(100, 5);
      settle();

      if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/wpd_pkg.sv
design/wpd_front.sv
design/wpd_queue.sv
design/wpd_back.sv
design/wwvb_pulse_deframer.sv
sim/wwvb_pulse_deframer_tb.sv
